// ===== rtl/core/cfp_pkg.sv =====
// ----------------------------------------------------------------------------
// cfp_pkg
// Shared widths, operation codes and status codes for the circular fifo
// ----------------------------------------------------------------------------
package cfp_pkg;

  localparam int DATA_W    = 32;
  localparam int OP_W      = 3;
  localparam int IDX_W     = 4;
  localparam int ST_W      = 2;
  localparam int CNT_W     = 5;
  localparam int CAP_RESET = 16;

  typedef enum logic [OP_W-1:0] {
    OP_ENQUEUE    = 3'd0,
    OP_DEQUEUE    = 3'd1,
    OP_PEEK       = 3'd2,
    OP_READ_FRONT = 3'd3,
    OP_READ_BACK  = 3'd4
  } op_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_BAD_INDEX = 2'd3
  } status_t;

endpackage

// ===== rtl/core/cfp_cfg_if.sv =====
// ----------------------------------------------------------------------------
// cfp_cfg_if
// Configuration write channel carrying the capacity register value
// ----------------------------------------------------------------------------
interface cfp_cfg_if import cfp_pkg::*; ();

  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

// ===== rtl/core/cfp_cmd_if.sv =====
// ----------------------------------------------------------------------------
// cfp_cmd_if
// Operation channel: one queue operation per transfer
// ----------------------------------------------------------------------------
interface cfp_cmd_if import cfp_pkg::*; ();

  logic                     valid;
  logic                     ready;
  logic [OP_W-1:0]          operation;
  logic signed [DATA_W-1:0] push_value;
  logic [IDX_W-1:0]         slot_index;

  modport source (output valid, output operation, output push_value, output slot_index,
                  input ready);
  modport sink   (input valid, input operation, input push_value, input slot_index,
                  output ready);

endinterface

// ===== rtl/core/cfp_rsp_if.sv =====
// ----------------------------------------------------------------------------
// cfp_rsp_if
// Result channel: read data, status and occupancy flags per operation
// ----------------------------------------------------------------------------
interface cfp_rsp_if import cfp_pkg::*; ();

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] read_data;
  logic [ST_W-1:0]          status;
  logic [CNT_W-1:0]         occupancy;
  logic                     is_full;
  logic                     is_empty;

  modport source (output valid, output read_data, output status, output occupancy,
                  output is_full, output is_empty, input ready);
  modport sink   (input valid, input read_data, input status, input occupancy,
                  input is_full, input is_empty, output ready);

endinterface

// ===== rtl/core/cfp_slot_ram.sv =====
// ----------------------------------------------------------------------------
// cfp_slot_ram
// Slot store: one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module cfp_slot_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/circular_fifo_with_peek.sv =====
// ----------------------------------------------------------------------------
// circular_fifo_with_peek
// Ring-buffer queue of signed words with enqueue, dequeue, peek, front, back
// ----------------------------------------------------------------------------
// One operation is taken per clock and its result appears on rsp in the next
// cycle, so the block sustains one item per cycle while rsp is ready; a
// stalled result holds cmd off. The latency comes from the single read port
// of the slot memory, whose read data is registered: every accepted operation
// issues one read and at most one write. Pointers, count and capacity sit in
// flip-flops; the slot memory is never cleared and needs no start-up pass.
// A capacity write empties the queue and should only be made while idle.
module circular_fifo_with_peek import cfp_pkg::*; #(
  parameter int MAX_DEPTH = 16
) (
  input  logic      clk,
  input  logic      rst,
  cfp_cfg_if.sink   cfg,
  cfp_cmd_if.sink   cmd,
  cfp_rsp_if.source rsp
);

  localparam int PTR_W     = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
  localparam int WIDE      = (PTR_W + 1 > CNT_W) ? PTR_W + 1 : CNT_W;
  localparam int DIST_W    = WIDE + 1;
  localparam int RESET_CAP = (MAX_DEPTH < CAP_RESET) ? MAX_DEPTH : CAP_RESET;

  logic [PTR_W-1:0]  head, head_next;
  logic [PTR_W-1:0]  tail, tail_next;
  logic [CNT_W-1:0]  count, count_next;
  logic [CNT_W-1:0]  cap, cap_cfg;

  logic              cfg_xfer, cmd_xfer;
  logic              is_full_now, is_empty_now;
  logic [PTR_W-1:0]  head_step, tail_step, back;
  logic [DIST_W-1:0] ring_gap;
  logic              peek_ok;
  status_t           status_next;
  logic              use_mem_next;
  logic [PTR_W-1:0]  raddr;
  logic              we;

  logic              rsp_valid;
  status_t           rsp_status;
  logic [CNT_W-1:0]  rsp_occ;
  logic              rsp_full, rsp_empty, rsp_use_mem;
  logic [DATA_W-1:0] mem_q;

  assign cfg.ready = 1'b1;
  assign cfg_xfer  = cfg.valid && cfg.ready;
  assign cmd.ready = !rsp_valid || rsp.ready;
  assign cmd_xfer  = cmd.valid && cmd.ready;

  // clamp the written capacity to 1..MAX_DEPTH
  always_comb begin
    if (cfg.data == '0) begin
      cap_cfg = CNT_W'(1);
    end else if (int'(cfg.data) > MAX_DEPTH) begin
      cap_cfg = CNT_W'(MAX_DEPTH);
    end else begin
      cap_cfg = cfg.data;
    end
  end

  assign is_full_now  = count >= cap;
  assign is_empty_now = count == '0;
  assign head_step    = (WIDE'(head) + WIDE'(1) >= WIDE'(cap)) ? '0 : head + PTR_W'(1);
  assign tail_step    = (WIDE'(tail) + WIDE'(1) >= WIDE'(cap)) ? '0 : tail + PTR_W'(1);
  assign back         = (tail == '0) ? PTR_W'(cap - CNT_W'(1)) : tail - PTR_W'(1);

  // distance of the peeked slot from the head around the ring
  always_comb begin
    if (DIST_W'(cmd.slot_index) >= DIST_W'(head)) begin
      ring_gap = DIST_W'(cmd.slot_index) - DIST_W'(head);
    end else begin
      ring_gap = DIST_W'(cmd.slot_index) + DIST_W'(cap) - DIST_W'(head);
    end
  end

  assign peek_ok = (WIDE'(cmd.slot_index) < WIDE'(cap)) && (ring_gap < DIST_W'(count));

  always_comb begin
    head_next    = head;
    tail_next    = tail;
    count_next   = count;
    status_next  = ST_OK;
    use_mem_next = 1'b0;
    raddr        = head;
    we           = 1'b0;
    case (cmd.operation)
      OP_ENQUEUE: begin
        if (is_full_now) begin
          status_next = ST_FULL;
        end else begin
          we         = 1'b1;
          tail_next  = tail_step;
          count_next = count + CNT_W'(1);
        end
      end
      OP_DEQUEUE: begin
        if (is_empty_now) begin
          status_next = ST_EMPTY;
        end else begin
          use_mem_next = 1'b1;
          head_next    = head_step;
          count_next   = count - CNT_W'(1);
        end
      end
      OP_PEEK: begin
        raddr = PTR_W'(cmd.slot_index);
        if (is_empty_now) begin
          status_next = ST_EMPTY;
        end else if (peek_ok) begin
          use_mem_next = 1'b1;
        end else begin
          status_next = ST_BAD_INDEX;
        end
      end
      OP_READ_FRONT: begin
        if (is_empty_now) begin
          status_next = ST_EMPTY;
        end else begin
          use_mem_next = 1'b1;
        end
      end
      OP_READ_BACK: begin
        raddr = back;
        if (is_empty_now) begin
          status_next = ST_EMPTY;
        end else begin
          use_mem_next = 1'b1;
        end
      end
      default: begin
        status_next = ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= '0;
      tail      <= '0;
      count     <= '0;
      cap       <= CNT_W'(RESET_CAP);
      rsp_valid <= 1'b0;
    end else begin
      if (cfg_xfer) begin
        head  <= '0;
        tail  <= '0;
        count <= '0;
        cap   <= cap_cfg;
      end else if (cmd_xfer) begin
        head  <= head_next;
        tail  <= tail_next;
        count <= count_next;
      end
      if (cmd_xfer) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_xfer) begin
      rsp_status  <= status_next;
      rsp_use_mem <= use_mem_next;
      rsp_occ     <= count_next;
      rsp_full    <= count_next >= cap;
      rsp_empty   <= count_next == '0;
    end
  end

  cfp_slot_ram #(
    .DEPTH (MAX_DEPTH),
    .WIDTH (DATA_W)
  ) u_slot_ram (
    .clk   (clk),
    .we    (cmd_xfer && we && !cfg_xfer),
    .waddr (tail),
    .wdata (cmd.push_value),
    .re    (cmd_xfer),
    .raddr (raddr),
    .rdata (mem_q)
  );

  assign rsp.valid     = rsp_valid;
  assign rsp.read_data = rsp_use_mem ? mem_q : '0;
  assign rsp.status    = rsp_status;
  assign rsp.occupancy = rsp_occ;
  assign rsp.is_full   = rsp_full;
  assign rsp.is_empty  = rsp_empty;

  a_count_in_cap: assert property (@(posedge clk) disable iff (rst)
    count <= cap)
    else $error("occupancy beyond capacity");

  a_empty_ptrs: assert property (@(posedge clk) disable iff (rst)
    count == '0 |-> head == tail)
    else $error("empty queue with pointers apart");

  a_dequeue_count: assert property (@(posedge clk) disable iff (rst)
    cmd_xfer && !cfg_xfer && cmd.operation == OP_DEQUEUE && count != '0
      |=> count == $past(count) - CNT_W'(1))
    else $error("dequeue did not lower the count");

  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !rsp.ready |-> !cmd.ready)
    else $error("operation taken while result stalled");

endmodule

// ===== tb/cfp_queue_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfp_queue_checker
// Watches the capacity, operation and result channels, keeps its own copy of
// the ring, pointers and count, predicts the result of every accepted
// operation and compares each returned result with the oldest prediction
// ----------------------------------------------------------------------------
module cfp_queue_checker import cfp_pkg::*; #(
  parameter int MAX_DEPTH = 16
) (
  input  logic clk,
  input  logic rst,
  cfp_cfg_if   cfg,
  cfp_cmd_if   cmd,
  cfp_rsp_if   rsp,
  output int   fail_count,
  output int   pending_count,
  output int   checked_count,
  output int   reject_count
);

  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic signed [DATA_W-1:0] read_data;
    status_t                  status;
    logic [CNT_W-1:0]         occupancy;
    logic                     is_full;
    logic                     is_empty;
  } queue_result_t;

  logic signed [DATA_W-1:0] ring_words [MAX_DEPTH];
  logic [IDX_W-1:0]         front_slot;
  logic [IDX_W-1:0]         write_slot;
  logic [CNT_W-1:0]         held_words;
  logic [CNT_W-1:0]         capacity_reg;
  queue_result_t            awaited_results [$];

  function automatic logic [CNT_W-1:0] usable_capacity(input logic [CNT_W-1:0] raw);
    if (raw == 0) return CNT_W'(1);
    if (int'(raw) > MAX_DEPTH) return CNT_W'(MAX_DEPTH);
    return raw;
  endfunction

  function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] slot,
                                                 input logic [CNT_W-1:0] cap);
    return (int'(slot) + 1 >= int'(cap)) ? '0 : slot + 1'b1;
  endfunction

  function automatic queue_result_t predict_operation(input logic [OP_W-1:0] op,
                                                      input logic signed [DATA_W-1:0] word,
                                                      input logic [IDX_W-1:0] slot);
    queue_result_t    res;
    logic [CNT_W-1:0] cap;
    int               distance;
    cap           = usable_capacity(capacity_reg);
    res.read_data = '0;
    res.status    = ST_OK;
    case (op)
      OP_ENQUEUE: begin
        if (held_words >= cap) begin
          res.status = ST_FULL;
        end else begin
          ring_words[write_slot] = word;
          write_slot = next_slot(write_slot, cap);
          held_words = held_words + 1'b1;
        end
      end
      OP_DEQUEUE, OP_PEEK, OP_READ_FRONT, OP_READ_BACK: begin
        if (held_words == 0) begin
          res.status = ST_EMPTY;
        end else if (op == OP_DEQUEUE) begin
          res.read_data = ring_words[front_slot];
          front_slot = next_slot(front_slot, cap);
          held_words = held_words - 1'b1;
        end else if (op == OP_PEEK) begin
          if (int'(slot) >= int'(cap)) begin
            res.status = ST_BAD_INDEX;
          end else begin
            distance = (slot >= front_slot) ? int'(slot) - int'(front_slot)
                                            : int'(slot) + int'(cap) - int'(front_slot);
            if (distance < int'(held_words)) res.read_data = ring_words[slot];
            else res.status = ST_BAD_INDEX;
          end
        end else if (op == OP_READ_FRONT) begin
          res.read_data = ring_words[front_slot];
        end else begin
          res.read_data = (write_slot == 0) ? ring_words[IDX_W'(cap - 1'b1)]
                                            : ring_words[write_slot - 1'b1];
        end
      end
      default: ;
    endcase
    res.occupancy = held_words;
    res.is_full   = (held_words >= cap);
    res.is_empty  = (held_words == 0);
    return res;
  endfunction

  function automatic void flag_failure(input string msg);
    fail_count++;
    if (fail_count <= REPORT_LIMIT) $display("mismatch: %s", msg);
  endfunction

  always @(posedge clk) begin
    queue_result_t got;
    queue_result_t want;
    if (rst) begin
      awaited_results.delete();
      front_slot   = '0;
      write_slot   = '0;
      held_words   = '0;
      capacity_reg = CNT_W'(CAP_RESET);
      for (int i = 0; i < MAX_DEPTH; i++) ring_words[i] = '0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        got.read_data = rsp.read_data;
        got.status    = status_t'(rsp.status);
        got.occupancy = rsp.occupancy;
        got.is_full   = rsp.is_full;
        got.is_empty  = rsp.is_empty;
        checked_count++;
        if (awaited_results.size() == 0) begin
          flag_failure($sformatf("result %0d with nothing outstanding: data %0d status %0d occ %0d",
                                 checked_count, got.read_data, got.status, got.occupancy));
        end else begin
          want = awaited_results.pop_front();
          if (want.status != ST_OK) reject_count++;
          if (got !== want) begin
            flag_failure($sformatf({"result %0d: expected data %0d status %0d occ %0d full %b ",
                                    "empty %b, got data %0d status %0d occ %0d full %b empty %b"},
                                   checked_count, want.read_data, want.status, want.occupancy,
                                   want.is_full, want.is_empty, got.read_data, got.status,
                                   got.occupancy, got.is_full, got.is_empty));
          end
        end
      end
      if (cfg.valid && cfg.ready) begin
        capacity_reg = cfg.data;
        front_slot   = '0;
        write_slot   = '0;
        held_words   = '0;
      end
      if (cmd.valid && cmd.ready) begin
        awaited_results.push_back(predict_operation(cmd.operation, cmd.push_value,
                                                    cmd.slot_index));
      end
    end
    pending_count = awaited_results.size();
  end

endmodule

// ===== tb/tb_circular_fifo_with_peek.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_circular_fifo_with_peek
// Drives directed and random queue operations through the circular fifo over
// a range of capacity settings and handshake pressure, including a long
// result stall that backs up the operation channel; the checker beside the
// block predicts and compares every result
// ----------------------------------------------------------------------------
module tb_circular_fifo_with_peek;
  import cfp_pkg::*;

  localparam int MAX_DEPTH    = 16;
  localparam int CLK_PERIOD   = 12;
  localparam int RESET_CYCLES = 5;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 4;
  localparam int OP_CODE_LAST = (1 << OP_W) - 1;
  localparam int PHASE_ITEMS  = 50;
  localparam int HOLD_CYCLES  = 48;

  logic clk;
  logic rst;

  cfp_cfg_if cfg_ch ();
  cfp_cmd_if cmd_ch ();
  cfp_rsp_if rsp_ch ();

  int fail_count;
  int pending_count;
  int checked_count;
  int reject_count;
  int send_idle_pct;
  int recv_stall_pct;
  int hold_off_request;
  int cycle_count;
  int settings_used;

  circular_fifo_with_peek #(.MAX_DEPTH(MAX_DEPTH)) dut (
    .clk (clk),
    .rst (rst),
    .cfg (cfg_ch),
    .cmd (cmd_ch),
    .rsp (rsp_ch)
  );

  cfp_queue_checker #(.MAX_DEPTH(MAX_DEPTH)) queue_checker (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg_ch),
    .cmd           (cmd_ch),
    .rsp           (rsp_ch),
    .fail_count    (fail_count),
    .pending_count (pending_count),
    .checked_count (checked_count),
    .reject_count  (reject_count)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("circular_fifo_with_peek regression: fail");
      $finish;
    end
  end

  // result side: random stalls plus an occasional long hold-off
  initial begin : result_side
    int hold_left;
    hold_left    = 0;
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_request > 0) begin
        hold_left        = hold_off_request;
        hold_off_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  function automatic logic [OP_W-1:0] pick_operation(input bit filling);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 4) return OP_W'($urandom_range(OP_READ_BACK + 1, OP_CODE_LAST));
    if (roll < (filling ? 82 : 30)) return OP_ENQUEUE;
    if (roll < (filling ? 88 : 70)) return OP_DEQUEUE;
    if (roll < (filling ? 94 : 86)) return OP_PEEK;
    if (roll < (filling ? 97 : 93)) return OP_READ_FRONT;
    return OP_READ_BACK;
  endfunction

  task automatic send_op(input logic [OP_W-1:0] op, input logic signed [DATA_W-1:0] word,
                         input logic [IDX_W-1:0] slot);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      cmd_ch.valid <= 1'b0;
      @(negedge clk);
    end
    cmd_ch.valid      <= 1'b1;
    cmd_ch.operation  <= op;
    cmd_ch.push_value <= word;
    cmd_ch.slot_index <= slot;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_capacity(input int raw_capacity);
    cmd_ch.valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= CNT_W'(raw_capacity);
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    settings_used++;
  endtask

  task automatic run_phase(input int raw_capacity, input int send_pct, input int stall_pct,
                           input int items, input int hold_cycles);
    int  usable;
    int  burst_left;
    bit  filling;
    write_capacity(raw_capacity);
    usable           = (raw_capacity < 1) ? 1 : (raw_capacity > MAX_DEPTH) ? MAX_DEPTH
                                                                           : raw_capacity;
    send_idle_pct    = send_pct;
    recv_stall_pct   = stall_pct;
    hold_off_request = hold_cycles;
    filling          = 1'b1;
    burst_left       = usable + 8;
    repeat (items) begin
      if (burst_left == 0) begin
        filling    = !filling;
        burst_left = usable + 8;
      end
      burst_left--;
      send_op(pick_operation(filling), $urandom,
              IDX_W'($urandom_range(0, 1) ? $urandom_range(0, usable - 1)
                                          : $urandom_range(0, MAX_DEPTH - 1)));
    end
  endtask

  initial begin : stimulus
    rst               = 1'b1;
    cfg_ch.valid      = 1'b0;
    cfg_ch.data       = '0;
    cmd_ch.valid      = 1'b0;
    cmd_ch.operation  = OP_ENQUEUE;
    cmd_ch.push_value = '0;
    cmd_ch.slot_index = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // empty queue at reset capacity
    send_op(OP_DEQUEUE, 0, 0);
    send_op(OP_PEEK, 0, 0);
    send_op(OP_READ_FRONT, 0, 0);
    send_op(OP_READ_BACK, 0, 0);
    // extreme words, then reads over them
    send_op(OP_ENQUEUE, 32'sh8000_0000, 0);
    send_op(OP_ENQUEUE, 32'sh7fff_ffff, 0);
    send_op(OP_ENQUEUE, -1, 0);
    send_op(OP_ENQUEUE, 0, 0);
    send_op(OP_READ_FRONT, 0, 0);
    send_op(OP_READ_BACK, 0, 0);
    send_op(OP_PEEK, 0, 0);
    send_op(OP_PEEK, 0, 3);
    send_op(OP_PEEK, 0, 4);
    send_op(OP_PEEK, 0, 15);
    for (int code = OP_READ_BACK + 1; code <= OP_CODE_LAST; code++) begin
      send_op(OP_W'(code), 32'sh5555_5555, 4'hf);
    end
    send_op(OP_DEQUEUE, 0, 0);
    send_op(OP_PEEK, 0, 0);
    // two-slot ring: full reject, index past capacity, wrap of the tail pointer
    write_capacity(2);
    send_op(OP_ENQUEUE, 32'sh5555_5555, 0);
    send_op(OP_ENQUEUE, 32'shaaaa_aaaa, 0);
    send_op(OP_ENQUEUE, 7, 0);
    send_op(OP_PEEK, 0, 2);
    send_op(OP_DEQUEUE, 0, 0);
    send_op(OP_ENQUEUE, 32'sh1234_5678, 0);
    send_op(OP_READ_BACK, 0, 0);
    send_op(OP_PEEK, 0, 0);

    run_phase(16, 0, 0, PHASE_ITEMS, 0);
    run_phase(1, 58, 0, PHASE_ITEMS, 0);
    run_phase(0, 0, 58, PHASE_ITEMS, 0);
    run_phase(31, 15, 15, PHASE_ITEMS, 0);
    run_phase(2, 0, 58, PHASE_ITEMS, 0);
    run_phase(5, 58, 0, PHASE_ITEMS, 0);
    run_phase($urandom_range(3, MAX_DEPTH), 15, 15, PHASE_ITEMS, 0);
    run_phase(16, 0, 0, PHASE_ITEMS + 20, HOLD_CYCLES);

    cmd_ch.valid   <= 1'b0;
    recv_stall_pct  = 0;
    while (pending_count != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("checked %0d results over %0d capacity writes", checked_count, settings_used);
    $display("%0d of them were full, empty or bad-index rejects", reject_count);
    if (fail_count == 0) begin
      $display("circular_fifo_with_peek regression: pass");
    end else begin
      $display("circular_fifo_with_peek regression: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/cfp_pkg.sv
rtl/core/cfp_cfg_if.sv
rtl/core/cfp_cmd_if.sv
rtl/core/cfp_rsp_if.sv
rtl/core/cfp_slot_ram.sv
rtl/core/circular_fifo_with_peek.sv
tb/cfp_queue_checker.sv
tb/tb_circular_fifo_with_peek.sv
